>>> sv/tplh_pkg.sv
// tplh_pkg: shared types, codes and constants of the two-level hash lookup.
// Used by every module of the block through scoped names; depends on nothing.

package tplh_pkg;

    // prime modulus of the universal hash and its scaled reciprocal
    localparam logic [15:0] PRIME = 16'd49999;
    localparam logic [31:0] RECIP = 32'((64'd1 << 47) / 64'd49999);

    // hash result width (second-level modulus is up to 11 bits)
    localparam int unsigned HW = 11;

    // queue between front and back
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QPTR_W = 3;
    localparam int unsigned QCNT_W = 4;

    typedef enum logic [1:0] {
        FN_BUCKET = 2'd0,
        FN_SLOT   = 2'd1,
        FN_LOOKUP = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_NO_BUCKET = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_WRITTEN   = 3'd4,
        ST_BAD_ADDR  = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  addr;
        logic [31:0] key;
        logic [31:0] value;
        logic [15:0] sub_alpha;
        logic [15:0] sub_beta;
        logic [10:0] sub_size;
        logic [9:0]  sub_base;
        logic        present;
        logic [8:0]  bucket_idx;   // first-level hash, filled by the front
        logic        bkt_hit;      // bucket in range and present, filled by the back
        logic [9:0]  bkt_base;     // slot base of that bucket
    } item_t;

    typedef struct packed {
        logic        present;
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [10:0] size;
        logic [9:0]  base;
    } bucket_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // one restoring division step of a remainder
    function automatic logic [HW-1:0] mod_step(logic [HW-1:0] rem, logic bit_in,
                                               logic [HW-1:0] m);
        logic [HW:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[HW-1:0];
    endfunction

endpackage

>>> sv/two_level_perfect_hash_lookup.sv
// Two-level perfect-hash lookup engine: takes one item per clock when the result
// side keeps up; bucket writes, slot writes and lookups apply in arrival order.
// Depends on tplh_pkg, tplh_front, tplh_queue, tplh_back.

// Rate: one item per cycle sustained while the result side keeps up. An item
// passes the front hash pipeline (multiply, add and reciprocal multiply,
// quotient multiply, correction, two division stages), the queue, the bucket
// store, the second-level hash, the slot store and the output register. The
// queue holds eight items; s_tready drops when eight are in the front pipe or
// queue, so a stalled result side backs up into the queue before the input is
// held off. After reset a clearing pass of max(BUCKETS, SLOTS) entries empties
// the bucket and slot stores; s_tready stays low during it, while register
// writes are taken. Register writes should be issued only with the block idle.

module two_level_perfect_hash_lookup #(
    parameter int unsigned BUCKETS = 256,
    parameter int unsigned SLOTS   = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // table_addr, key_hash, entry_value, sub_alpha, sub_beta, sub_size,
    // sub_base, entry_present
    input  logic [127:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_value
    output logic [31:0]  m_tdata,
    // status
    output logic [2:0]   m_tuser
);

    tplh_pkg::item_t   in_item;
    tplh_pkg::item_t   push_item;
    tplh_pkg::item_t   head;
    tplh_pkg::q_stat_t qstat;
    logic              accept;
    logic              push;
    logic              pop;
    logic              busy;

    // unpack the input item; the back-end fields start empty
    always_comb
    begin
        in_item            = '0;
        in_item.func       = s_tuser;
        in_item.addr       = s_tdata[9:0];
        in_item.key        = s_tdata[41:10];
        in_item.value      = s_tdata[73:42];
        in_item.sub_alpha  = s_tdata[89:74];
        in_item.sub_beta   = s_tdata[105:90];
        in_item.sub_size   = s_tdata[116:106];
        in_item.sub_base   = s_tdata[126:117];
        in_item.present    = s_tdata[127];
    end

    assign accept = s_tvalid && s_tready;

    tplh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .accept    (accept),
        .in_item   (in_item),
        .pop       (pop),
        .ready     (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    tplh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    tplh_back #(
        .BUCKETS (BUCKETS),
        .SLOTS   (SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .busy       (busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_value  (m_tdata)
    );

    // the credit count must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full && !pop))
        else $error("queue overflow");

    // no item enters while the stores are being cleared
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("item accepted during clearing pass");

    // anything other than a hit reports a zero value
    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != tplh_pkg::ST_HIT) |-> (m_tdata == 32'd0))
        else $error("nonzero value on miss");

endmodule

>>> sv/tplh_hash.sv
// tplh_hash: six-stage pipeline for h = ((a*k + b) mod 2^32 mod 49999) mod m.
// Carries one item record alongside. Depends on tplh_pkg.

module tplh_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [31:0]                  key,
    input  logic [15:0]                  alpha,
    input  logic [15:0]                  beta,
    input  logic [tplh_pkg::HW-1:0]      modulus,
    input  tplh_pkg::item_t              in_item,
    output logic                         out_valid,
    output logic [tplh_pkg::HW-1:0]      hash,
    output tplh_pkg::item_t              out_item
);

    logic [5:0]            vld_reg;
    tplh_pkg::item_t       item_reg [6];
    logic [tplh_pkg::HW-1:0] m_reg [5];

    logic [31:0] p1_reg;
    logic [15:0] b1_reg;
    logic [31:0] x2_reg;
    logic [16:0] q2_reg;
    logic [31:0] x3_reg;
    logic [31:0] qd3_reg;
    logic [15:0] r4_reg;
    logic [tplh_pkg::HW-1:0] rem5_reg;
    logic [7:0]  lo5_reg;
    logic [tplh_pkg::HW-1:0] h6_reg;

    logic [47:0] mul1;
    logic [31:0] x2_next;
    logic [63:0] mul2;
    logic [32:0] mul3;
    logic [31:0] r4_raw;
    logic [31:0] r4_next;
    logic [tplh_pkg::HW-1:0] m_eff;
    logic [tplh_pkg::HW-1:0] rem5_next;
    logic [tplh_pkg::HW-1:0] h6_next;

    assign m_eff   = (modulus == '0) ? tplh_pkg::HW'(1) : modulus;
    assign mul1    = 48'(alpha) * 48'(key);
    assign x2_next = p1_reg + 32'(b1_reg);
    assign mul2    = 64'(x2_next) * 64'(tplh_pkg::RECIP);
    assign mul3    = 33'(q2_reg) * 33'(tplh_pkg::PRIME);
    assign r4_raw  = x3_reg - qd3_reg;
    assign r4_next = (r4_raw >= 32'(tplh_pkg::PRIME)) ? r4_raw - 32'(tplh_pkg::PRIME) : r4_raw;

    always_comb
    begin
        logic [tplh_pkg::HW-1:0] r;
        r = '0;
        for (int i = 15; i >= 8; i--)
        begin
            r = tplh_pkg::mod_step(r, r4_reg[i], m_reg[3]);
        end
        rem5_next = r;
    end

    always_comb
    begin
        logic [tplh_pkg::HW-1:0] r;
        r = rem5_reg;
        for (int i = 7; i >= 0; i--)
        begin
            r = tplh_pkg::mod_step(r, lo5_reg[i], m_reg[4]);
        end
        h6_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= in_item;
            for (int i = 1; i < 6; i++)
            begin
                item_reg[i] <= item_reg[i-1];
            end
            m_reg[0] <= m_eff;
            for (int i = 1; i < 5; i++)
            begin
                m_reg[i] <= m_reg[i-1];
            end
            p1_reg   <= mul1[31:0];
            b1_reg   <= beta;
            x2_reg   <= x2_next;
            q2_reg   <= mul2[63:47];
            x3_reg   <= x2_reg;
            qd3_reg  <= mul3[31:0];
            r4_reg   <= r4_next[15:0];
            rem5_reg <= rem5_next;
            lo5_reg  <= r4_reg[7:0];
            h6_reg   <= h6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign hash      = h6_reg;
    assign out_item  = item_reg[5];

endmodule

>>> sv/tplh_queue.sv
// tplh_queue: small register queue of item records between front and back.
// Depends on tplh_pkg.

module tplh_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tplh_pkg::item_t   push_item,
    input  logic              pop,
    output tplh_pkg::item_t   head,
    output tplh_pkg::q_stat_t stat
);

    tplh_pkg::item_t                 mem_reg [tplh_pkg::QDEPTH];
    logic [tplh_pkg::QPTR_W-1:0]     wr_reg;
    logic [tplh_pkg::QPTR_W-1:0]     rd_reg;
    logic [tplh_pkg::QCNT_W-1:0]     cnt_reg;
    logic [tplh_pkg::QCNT_W-1:0]     cnt_next;

    assign cnt_next = cnt_reg + tplh_pkg::QCNT_W'(push) - tplh_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    assign head       = mem_reg[rd_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == tplh_pkg::QCNT_W'(tplh_pkg::QDEPTH));

endmodule

>>> sv/tplh_front.sv
// tplh_front: accepts items, holds the first-level hash registers, computes
// the bucket index and pushes the record into the queue. Depends on tplh_pkg, tplh_hash.

module tplh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_data,
    input  logic              busy,
    input  logic              accept,
    input  tplh_pkg::item_t   in_item,
    input  logic              pop,
    output logic              ready,
    output logic              push,
    output tplh_pkg::item_t   push_item
);

    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_BETA    = 2'd1;
    localparam logic [1:0] REG_BUCKETS = 2'd2;

    logic [15:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [8:0]  buckets_reg;
    logic [tplh_pkg::QCNT_W-1:0] occ_reg;
    logic [tplh_pkg::QCNT_W-1:0] occ_next;

    logic [tplh_pkg::HW-1:0] hash;
    tplh_pkg::item_t         hash_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 16'd0;
            beta_reg    <= 16'd1;
            buckets_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ALPHA:   alpha_reg   <= cfg_data;
                REG_BETA:    beta_reg    <= cfg_data;
                REG_BUCKETS: buckets_reg <= cfg_data[8:0];
                default:     ;
            endcase
        end
    end

    // items in the hash pipe plus items in the queue
    assign occ_next = occ_reg + tplh_pkg::QCNT_W'(accept) - tplh_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign ready = !busy && (occ_reg < tplh_pkg::QCNT_W'(tplh_pkg::QDEPTH));

    tplh_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (1'b1),
        .in_valid  (accept),
        .key       (in_item.key),
        .alpha     (alpha_reg),
        .beta      (beta_reg),
        .modulus   (tplh_pkg::HW'(buckets_reg)),
        .in_item   (in_item),
        .out_valid (push),
        .hash      (hash),
        .out_item  (hash_item)
    );

    // bucket index is below 511, so nine bits hold it
    always_comb
    begin
        push_item            = hash_item;
        push_item.bucket_idx = hash[8:0];
    end

endmodule

>>> sv/tplh_back.sv
// tplh_back: bucket store, second-level hash, slot store and result register.
// Runs a clearing pass after reset. Depends on tplh_pkg, tplh_hash.

module tplh_back #(
    parameter int unsigned BUCKETS = 256,
    parameter int unsigned SLOTS   = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tplh_pkg::item_t   head,
    input  tplh_pkg::q_stat_t qstat,
    output logic              pop,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_status,
    output logic [31:0]       out_value
);

    localparam int unsigned BIDX_W = $clog2(BUCKETS);
    localparam int unsigned SIDX_W = $clog2(SLOTS);
    localparam int unsigned CLR_N  = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
    localparam int unsigned CLR_W  = $clog2(CLR_N);

    tplh_pkg::bucket_t bkt_mem [BUCKETS];
    logic [32:0]       key_mem [SLOTS];
    logic [31:0]       val_mem [SLOTS];

    logic              clr_reg;
    logic [CLR_W-1:0]  clr_idx_reg;

    logic              adv;
    logic              v2_reg;
    tplh_pkg::item_t   it2_reg;
    logic              bok2_reg;
    tplh_pkg::bucket_t bkt_rd_reg;
    tplh_pkg::item_t   it2_hash;

    logic                    v8;
    logic [tplh_pkg::HW-1:0] h8;
    tplh_pkg::item_t         it8;
    logic [11:0]             sa8;
    logic                    sa_ok8;

    logic              v9_reg;
    tplh_pkg::item_t   it9_reg;
    logic              sa_ok9_reg;
    logic [32:0]       key_rd_reg;
    logic [31:0]       val_rd_reg;

    logic [2:0]        st9;
    logic [31:0]       fv9;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [31:0]       value_reg;

    assign adv  = !out_valid_reg || out_ready;
    assign pop  = adv && !qstat.empty && !clr_reg;
    assign busy = clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == CLR_W'(CLR_N - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // bucket store: written and read by the item at the queue head
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            if (32'(clr_idx_reg) < BUCKETS)
            begin
                bkt_mem[BIDX_W'(clr_idx_reg)] <= '0;
            end
        end
        else if (pop && head.func == tplh_pkg::FN_BUCKET && 32'(head.addr) < BUCKETS)
        begin
            bkt_mem[BIDX_W'(head.addr)] <= {head.present, head.sub_alpha, head.sub_beta,
                                            head.sub_size, head.sub_base};
        end
        if (adv)
        begin
            bkt_rd_reg <= bkt_mem[BIDX_W'(head.bucket_idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it2_reg  <= head;
            bok2_reg <= 32'(head.bucket_idx) < BUCKETS;
        end
    end

    always_comb
    begin
        it2_hash          = it2_reg;
        it2_hash.bkt_hit  = bok2_reg && bkt_rd_reg.present;
        it2_hash.bkt_base = bkt_rd_reg.base;
    end

    tplh_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v2_reg),
        .key       (it2_reg.key),
        .alpha     (bkt_rd_reg.alpha),
        .beta      (bkt_rd_reg.beta),
        .modulus   (bkt_rd_reg.size),
        .in_item   (it2_hash),
        .out_valid (v8),
        .hash      (h8),
        .out_item  (it8)
    );

    assign sa8    = 12'(it8.bkt_base) + 12'(h8);
    assign sa_ok8 = 32'(sa8) < SLOTS;

    // slot store: keys carry a valid bit and are cleared, values are not
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            if (32'(clr_idx_reg) < SLOTS)
            begin
                key_mem[SIDX_W'(clr_idx_reg)] <= '0;
            end
        end
        else if (adv && v8 && it8.func == tplh_pkg::FN_SLOT && 32'(it8.addr) < SLOTS)
        begin
            key_mem[SIDX_W'(it8.addr)] <= {it8.present, it8.key};
        end
        if (adv)
        begin
            key_rd_reg <= key_mem[SIDX_W'(sa8)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v8 && it8.func == tplh_pkg::FN_SLOT && 32'(it8.addr) < SLOTS)
        begin
            val_mem[SIDX_W'(it8.addr)] <= it8.value;
        end
        if (adv)
        begin
            val_rd_reg <= val_mem[SIDX_W'(sa8)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v9_reg <= v8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it9_reg    <= it8;
            sa_ok9_reg <= sa_ok8;
        end
    end

    always_comb
    begin
        st9 = tplh_pkg::ST_BAD_ADDR;
        fv9 = 32'd0;
        case (it9_reg.func)
            tplh_pkg::FN_BUCKET:
            begin
                if (32'(it9_reg.addr) < BUCKETS)
                begin
                    st9 = tplh_pkg::ST_WRITTEN;
                end
            end
            tplh_pkg::FN_SLOT:
            begin
                if (32'(it9_reg.addr) < SLOTS)
                begin
                    st9 = tplh_pkg::ST_WRITTEN;
                end
            end
            tplh_pkg::FN_LOOKUP:
            begin
                if (!it9_reg.bkt_hit)
                begin
                    st9 = tplh_pkg::ST_NO_BUCKET;
                end
                else if (!sa_ok9_reg)
                begin
                    st9 = tplh_pkg::ST_BAD_ADDR;
                end
                else if (!key_rd_reg[32])
                begin
                    st9 = tplh_pkg::ST_EMPTY;
                end
                else if (key_rd_reg[31:0] != it9_reg.key)
                begin
                    st9 = tplh_pkg::ST_MISMATCH;
                end
                else
                begin
                    st9 = tplh_pkg::ST_HIT;
                    fv9 = val_rd_reg;
                end
            end
            default:
            begin
                st9 = tplh_pkg::ST_BAD_ADDR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= st9;
            value_reg  <= fv9;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_value  = value_reg;

endmodule

>>> verif/tb_two_level_perfect_hash_lookup.sv
// Testbench of the two-level perfect-hash lookup engine: directed and random items,
// checked against a predictor of the bucket and slot stores. Needs tplh_pkg and the RTL.
`timescale 1ns / 1ps

module tb_two_level_perfect_hash_lookup;

    localparam int NBKT = 256;
    localparam int NSLOT = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 30;
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA = 2'd1;
    localparam logic [1:0] REG_BUCKETS = 2'd2;
    localparam logic [1:0] FN_NONE = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [9:0]  addr;
        logic [31:0] key;
        logic [31:0] value;
        logic [15:0] s_alpha;
        logic [15:0] s_beta;
        logic [10:0] s_size;
        logic [9:0]  s_base;
        logic        present;
    } op_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
    } answer_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // table_addr, key_hash, entry_value, sub_alpha, sub_beta, sub_size,
    // sub_base, entry_present (lowest bits first)
    logic [127:0] s_tdata;
    // func
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // found_value
    logic [31:0]  m_tdata;
    // status
    logic [2:0]   m_tuser;

    two_level_perfect_hash_lookup dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // predictor copy of registers and stores
    logic [15:0]       top_a;
    logic [15:0]       top_b;
    logic [8:0]        top_m;
    tplh_pkg::bucket_t bkt [NBKT];
    logic              slot_on [NSLOT];
    logic [31:0]       slot_key [NSLOT];
    logic [31:0]       slot_val [NSLOT];

    answer_t     pending[$];
    logic [31:0] stored_keys[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_status [8];
    int          idle_cnt;
    int          hold_cnt;
    bit          no_stall;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // universal hash: ((a*k + b) mod 2^32 mod prime) mod m, m of zero acts as one
    function automatic logic [31:0] uhash(logic [31:0] k, logic [31:0] m,
                                          logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        t = a * k + b;
        t = t % 32'd49999;
        if (m == 0)
        begin
            m = 1;
        end
        return t % m;
    endfunction

    // bucket index and slot address a lookup of key would use
    function automatic void locate(logic [31:0] key, output logic [31:0] bi,
                                   output logic [31:0] sa);
        bi = uhash(key, 32'(top_m), 32'(top_a), 32'(top_b));
        sa = 32'hFFFF_FFFF;
        if (bi < NBKT)
        begin
            sa = 32'(bkt[bi].base) + uhash(key, 32'(bkt[bi].size), 32'(bkt[bi].alpha),
                                          32'(bkt[bi].beta));
        end
    endfunction

    function automatic answer_t lookup_result(op_t op);
        answer_t r;
        logic [31:0] bi;
        logic [31:0] sa;
        r.status = tplh_pkg::ST_BAD_ADDR;
        r.value = '0;
        case (op.func)
            tplh_pkg::FN_BUCKET:
            begin
                if (op.addr < NBKT)
                begin
                    bkt[op.addr] = '{op.present, op.s_alpha, op.s_beta, op.s_size, op.s_base};
                    r.status = tplh_pkg::ST_WRITTEN;
                end
            end
            tplh_pkg::FN_SLOT:
            begin
                slot_on[op.addr] = op.present;
                slot_key[op.addr] = op.key;
                slot_val[op.addr] = op.value;
                r.status = tplh_pkg::ST_WRITTEN;
            end
            tplh_pkg::FN_LOOKUP:
            begin
                locate(op.key, bi, sa);
                if (bi >= NBKT || !bkt[bi].present)
                    r.status = tplh_pkg::ST_NO_BUCKET;
                else if (sa >= NSLOT)
                    r.status = tplh_pkg::ST_BAD_ADDR;
                else if (!slot_on[sa])
                    r.status = tplh_pkg::ST_EMPTY;
                else if (slot_key[sa] != op.key)
                    r.status = tplh_pkg::ST_MISMATCH;
                else
                begin
                    r.status = tplh_pkg::ST_HIT;
                    r.value = slot_val[sa];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = int'($urandom_range(99));
        if (no_stall || r < 65)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // receiver stall, changed at the falling edge; now and then a long hold
    always @(negedge clk)
    begin
        if ($urandom_range(199) == 0)
            no_stall <= ~no_stall;
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (!no_stall && $urandom_range(149) == 0)
        begin
            hold_cnt <= int'($urandom_range(10, 40));
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_stall ? 1'b1 : ($urandom_range(99) < 70);
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d value %h", $time, m_tuser, m_tdata);
            end
            else
            begin
                exp_r = pending.pop_front();
                n_status[exp_r.status]++;
                if (m_tuser !== exp_r.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_tuser);
                end
                if (m_tdata !== exp_r.value)
                begin
                    errors++;
                    $display("%0t: found_value expected %h actual %h", $time, exp_r.value,
                             m_tdata);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt == IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(op_t op);
        int g;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = op.func;
        s_tdata = {op.present, op.s_base, op.s_size, op.s_beta, op.s_alpha,
                   op.value, op.key, op.addr};
        do
            @(posedge clk);
        while (!s_tready);
        pending.push_back(lookup_result(op));
        n_items++;
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // hold the sender until the pipe has emptied, then let it settle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ALPHA: top_a = val;
            REG_BETA: top_b = val;
            REG_BUCKETS: top_m = val[8:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_regs(logic [15:0] a, logic [15:0] b, logic [15:0] m);
        drain();
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, b);
        write_reg(REG_BUCKETS, m);
    endtask

    function automatic op_t make_op(logic [1:0] f);
        op_t op;
        op = '{f, '0, '0, '0, '0, 16'd1, 11'd1, '0, 1'b1};
        return op;
    endfunction

    function automatic op_t noise_op();
        op_t op;
        op.func = 2'($urandom_range(3));
        op.addr = 10'($urandom);
        op.key = $urandom;
        op.value = $urandom;
        op.s_alpha = 16'($urandom);
        op.s_beta = 16'($urandom);
        op.s_size = 11'($urandom);
        op.s_base = 10'($urandom);
        op.present = 1'($urandom);
        return op;
    endfunction

    // store key in the slot its lookup will reach, if that slot exists
    task automatic place_key(logic [31:0] key, logic [31:0] value, logic present);
        op_t op;
        logic [31:0] bi;
        logic [31:0] sa;
        locate(key, bi, sa);
        if (sa < NSLOT)
        begin
            op = make_op(tplh_pkg::FN_SLOT);
            op.addr = 10'(sa);
            op.key = key;
            op.value = value;
            op.present = present;
            send(op);
            if (present)
                stored_keys.push_back(key);
        end
    endtask

    task automatic do_lookup(logic [31:0] key);
        op_t op;
        op = make_op(tplh_pkg::FN_LOOKUP);
        op.key = key;
        send(op);
    endtask

    task automatic test_directed();
        op_t op;
        logic [31:0] bi;
        logic [31:0] sa;
        logic [31:0] k;
        set_regs(16'd7, 16'd3, 16'd4);
        // bucket 0 absent, 1..3 present; bucket 3's slot base sits at the slot store's top edge
        for (int i = 0; i < 4; i++)
        begin
            op = make_op(tplh_pkg::FN_BUCKET);
            op.addr = 10'(i);
            op.present = (i != 0);
            op.s_alpha = (i == 1) ? 16'd49998 : 16'(5 + i);
            op.s_beta = (i == 2) ? 16'd49998 : 16'd1;
            op.s_size = (i == 3) ? 11'd2047 : ((i == 2) ? 11'd0 : 11'd9);
            op.s_base = (i == 3) ? 10'd1023 : 10'(i * 16);
            send(op);
        end
        // bucket write out of range, and the unused function code
        op = make_op(tplh_pkg::FN_BUCKET);
        op.addr = 10'd1023;
        send(op);
        op = noise_op();
        op.func = FN_NONE;
        send(op);
        // extremes of key and value: stored where the slot exists, then looked up
        place_key(32'h0, 32'hFFFF_FFFF, 1'b1);
        place_key(32'hFFFF_FFFF, 32'h0, 1'b1);
        do_lookup(32'h0);
        do_lookup(32'hFFFF_FFFF);
        // mismatch: slot holds a different key; empty: slot written absent
        k = 32'h1234_5678;
        locate(k, bi, sa);
        if (sa < NSLOT)
        begin
            op = make_op(tplh_pkg::FN_SLOT);
            op.addr = 10'(sa);
            op.key = ~k;
            op.value = 32'hA5A5_A5A5;
            send(op);
            do_lookup(k);
            op.key = k;
            op.present = 1'b0;
            send(op);
            do_lookup(k);
        end
        // random keys, which can land in any bucket, the absent one and the bad-address one too
        for (int i = 0; i < 8; i++)
            do_lookup($urandom);
    endtask

    // random table: up to 24 descriptors for buckets in use, then mostly stored keys
    task automatic test_table(logic [15:0] a, logic [15:0] b, logic [15:0] m, int count);
        op_t op;
        int used;
        int r;
        set_regs(a, b, m);
        stored_keys.delete();
        used = (m[8:0] == 0) ? 1 : int'(m[8:0]);
        if (used > NBKT)
            used = NBKT;
        for (int i = 0; i < used && i < 24; i++)
        begin
            op = make_op(tplh_pkg::FN_BUCKET);
            op.addr = (used <= 24) ? 10'(i) : 10'($urandom_range(used - 1));
            op.present = ($urandom_range(9) != 0);
            op.s_alpha = 16'($urandom_range(49998));
            op.s_beta = 16'($urandom_range(1, 49998));
            op.s_size = 11'($urandom_range(1, 16));
            op.s_base = 10'($urandom_range(0, 1015));
            send(op);
        end
        for (int i = 0; i < count; i++)
        begin
            r = int'($urandom_range(99));
            if (r < 35)
                place_key($urandom, $urandom, $urandom_range(7) != 0);
            else if (r < 75 && stored_keys.size() != 0)
                do_lookup(stored_keys[$urandom_range(stored_keys.size() - 1)]);
            else if (r < 85)
                do_lookup($urandom);
            else
                send(noise_op());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        no_stall = 1'b0;
        hold_cnt = 0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        idle_cnt = 0;
        top_a = 16'd0;
        top_b = 16'd1;
        top_m = 9'd1;
        foreach (n_status[i])
            n_status[i] = 0;
        foreach (bkt[i])
            bkt[i] = '0;
        foreach (slot_on[i])
        begin
            slot_on[i] = 1'b0;
            slot_key[i] = '0;
            slot_val[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the first item runs on the reset register values
        do_lookup($urandom);
        test_directed();
        test_table(16'd0, 16'd1, 16'd1, 60);
        test_table(16'd49998, 16'd49998, 16'd256, 120);
        test_table(16'($urandom_range(49998)), 16'($urandom_range(1, 49998)),
                   16'($urandom_range(2, 40)), 120);
        test_table(16'hFFFF, 16'd0, 16'd0, 60);
        test_table(16'($urandom_range(49998)), 16'($urandom_range(1, 49998)), 16'd511, 80);
        test_table(16'($urandom_range(49998)), 16'($urandom_range(1, 49998)),
                   16'($urandom_range(1, 8)), 80);

        drain();
        $display("%0d items sent, %0d results checked over eight register settings", n_items,
                 n_results);
        $display("hit %0d, no bucket %0d, empty %0d, mismatch %0d, written %0d, bad addr %0d",
                 n_status[tplh_pkg::ST_HIT], n_status[tplh_pkg::ST_NO_BUCKET],
                 n_status[tplh_pkg::ST_EMPTY], n_status[tplh_pkg::ST_MISMATCH],
                 n_status[tplh_pkg::ST_WRITTEN], n_status[tplh_pkg::ST_BAD_ADDR]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
sv/tplh_pkg.sv
sv/tplh_hash.sv
sv/tplh_queue.sv
sv/tplh_front.sv
sv/tplh_back.sv
sv/two_level_perfect_hash_lookup.sv
verif/tb_two_level_perfect_hash_lookup.sv
